@@ src/dibx_pkg.sv @@
package dibx_pkg;

  // build-time defaults for the top level parameters
  localparam int MAX_WIDTH_DEF     = 4096;
  localparam int PALETTE_DEPTH_DEF = 256;

  localparam int PIX_W = 32;

  // pixel depth codes held in the bit_mode register
  typedef enum logic [2:0] {
    MODE_1BPP  = 3'd0,
    MODE_4BPP  = 3'd1,
    MODE_8BPP  = 3'd2,
    MODE_24BPP = 3'd3,
    MODE_32BPP = 3'd4
  } bit_mode_t;

  // input opcodes
  localparam logic OPC_PALETTE = 1'b0;
  localparam logic OPC_DATA    = 1'b1;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_BIT_MODE   = 2'd0;
  localparam logic [1:0] REG_ROW_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE = 2'd2;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd3;

  // register reset values
  localparam logic [2:0]  BIT_MODE_RST   = 3'd2;
  localparam logic [12:0] ROW_WIDTH_RST  = 13'd1;
  localparam logic [14:0] ROW_STRIDE_RST = 15'd4;
  localparam logic [15:0] IMAGE_ROWS_RST = 16'd1;

  // how the pending job turns into pixel words
  typedef enum logic [1:0] {
    LK_BIT    = 2'd0,
    LK_NIBBLE = 2'd1,
    LK_BYTE   = 2'd2,
    LK_DIRECT = 2'd3
  } lookup_t;

endpackage

@@ src/dibx_ram.sv @@
module dibx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port, read returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/dib_row_pixel_expander.sv @@
// a data word passes the job register, the read stage and the output register to its first pixel
// throughput: one pixel per cycle through the single palette read port while pix_stall is low;
//   the source is stalled until the last pixel of the pending byte is issued
// reset: row position, column, row count, assembly and pipeline clear; registers take
//   their defaults; palette contents stay undefined until written, with no clearing pass
module dib_row_pixel_expander #(
  parameter int MAX_WIDTH     = dibx_pkg::MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = dibx_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // source words
  input  logic                       src_valid,
  output logic                       src_stall,
  input  logic                       opcode,
  input  logic [7:0]                 palette_index,
  input  logic [31:0]                palette_word,
  input  logic [7:0]                 data_byte,
  // pixel words
  output logic                       pix_valid,
  input  logic                       pix_stall,
  output logic [dibx_pkg::PIX_W-1:0] pixel_word,
  output logic                       end_of_row,
  output logic                       end_of_image,
  output logic                       last_of_item,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dibx_pkg::*;

  localparam int CW_RAW = $clog2(MAX_WIDTH + 1);
  localparam int CW     = (CW_RAW < 13) ? CW_RAW : 13;
  localparam int AW     = $clog2(PALETTE_DEPTH);

  // configuration registers
  logic [2:0]  bit_mode;
  logic [12:0] row_width;
  logic [14:0] row_stride_bytes;
  logic [15:0] image_rows;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_mode         <= BIT_MODE_RST;
      row_width        <= ROW_WIDTH_RST;
      row_stride_bytes <= ROW_STRIDE_RST;
      image_rows       <= IMAGE_ROWS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BIT_MODE:   bit_mode         <= pwdata[2:0];
        REG_ROW_WIDTH:  row_width        <= pwdata[12:0];
        REG_ROW_STRIDE: row_stride_bytes <= pwdata[14:0];
        REG_IMAGE_ROWS: image_rows       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_BIT_MODE:   prdata = {29'd0, bit_mode};
      REG_ROW_WIDTH:  prdata = {19'd0, row_width};
      REG_ROW_STRIDE: prdata = {17'd0, row_stride_bytes};
      REG_IMAGE_ROWS: prdata = {16'd0, image_rows};
      default:        prdata = 32'd0;
    endcase
  end

  // row position state
  logic [14:0] byte_in_row, byte_in_row_next;
  logic [CW-1:0] pixel_column, pixel_column_next;
  logic [15:0] row_counter, row_counter_next;
  logic [23:0] pixel_assembly, pixel_assembly_next;
  logic [1:0]  byte_phase, byte_phase_next;

  // pending job: the pixels of one accepted byte still to be issued
  logic          j_valid;
  lookup_t       j_kind;
  logic [7:0]    j_bits;
  logic [3:0]    j_left;
  logic [31:0]   j_word;
  logic          j_eor;
  logic          j_eoi;

  // read stage: palette data lands in the ram output register
  logic          r_valid;
  logic          r_use_ram;
  logic [31:0]   r_word;
  logic          r_last;
  logic          r_eor;
  logic          r_eoi;

  // handshake and pipeline movement
  logic src_take, data_take, pal_take;
  logic o_free, r_move, r_free, issue, j_done;

  assign o_free    = !pix_valid || !pix_stall;
  assign r_move    = r_valid && o_free;
  assign r_free    = !r_valid || r_move;
  assign issue     = j_valid && r_free;
  assign j_done    = issue && (j_left == 4'd1);
  assign src_stall = j_valid && !j_done;
  assign src_take  = src_valid && !src_stall;
  assign data_take = src_take && (opcode == OPC_DATA);
  assign pal_take  = src_take && (opcode == OPC_PALETTE);

  // per-byte decode of the row position
  logic [CW-1:0] width_eff, remaining, col_sum;
  logic          rem_nz, row_done, last_row, row_end;
  logic [14:0]   stride_eff;
  logic [15:0]   rows_eff;
  logic [15:0]   byte_sum;
  logic [16:0]   row_sum;
  logic [3:0]    n_pix;
  lookup_t       new_kind;
  logic [31:0]   new_word;

  always_comb begin
    width_eff  = ({19'd0, row_width} > MAX_WIDTH) ? CW'(MAX_WIDTH) : row_width[CW-1:0];
    stride_eff = (row_stride_bytes == 15'd0) ? 15'd1 : row_stride_bytes;
    rows_eff   = (image_rows == 16'd0) ? 16'd1 : image_rows;
    rem_nz     = pixel_column < width_eff;
    remaining  = width_eff - pixel_column;

    n_pix               = 4'd0;
    new_kind            = LK_BYTE;
    new_word            = 32'd0;
    pixel_assembly_next = pixel_assembly;
    byte_phase_next     = byte_phase;

    // pixel count and assembly per depth
    if (rem_nz) begin
      unique case (bit_mode)
        MODE_1BPP: begin
          n_pix    = (remaining >= CW'(8)) ? 4'd8 : remaining[3:0];
          new_kind = LK_BIT;
        end
        MODE_4BPP: begin
          n_pix    = (remaining > CW'(1)) ? 4'd2 : 4'd1;
          new_kind = LK_NIBBLE;
        end
        MODE_8BPP: begin
          n_pix    = 4'd1;
          new_kind = LK_BYTE;
        end
        MODE_24BPP: begin
          new_kind = LK_DIRECT;
          if (byte_phase >= 2'd2) begin
            n_pix               = 4'd1;
            new_word            = {8'd0, data_byte, pixel_assembly[15:0]};
            pixel_assembly_next = 24'd0;
            byte_phase_next     = 2'd0;
          end else begin
            pixel_assembly_next = pixel_assembly | (24'(data_byte) << {byte_phase, 3'd0});
            byte_phase_next     = byte_phase + 2'd1;
          end
        end
        MODE_32BPP: begin
          new_kind = LK_DIRECT;
          if (byte_phase == 2'd3) begin
            n_pix               = 4'd1;
            new_word            = {data_byte, pixel_assembly};
            pixel_assembly_next = 24'd0;
            byte_phase_next     = 2'd0;
          end else begin
            pixel_assembly_next = pixel_assembly | (24'(data_byte) << {byte_phase, 3'd0});
            byte_phase_next     = byte_phase + 2'd1;
          end
        end
        default: ;
      endcase
    end

    // column and end-of-row flags
    col_sum           = pixel_column + CW'(n_pix);
    pixel_column_next = col_sum;
    row_done          = (n_pix != 4'd0) && (col_sum >= width_eff);
    row_sum           = {1'b0, row_counter} + 17'd1;
    last_row          = row_sum >= {1'b0, rows_eff};

    // stride count and row advance
    byte_sum         = {1'b0, byte_in_row} + 16'd1;
    row_end          = byte_sum >= {1'b0, stride_eff};
    byte_in_row_next = byte_sum[14:0];
    row_counter_next = row_counter;
    if (row_end) begin
      byte_in_row_next    = 15'd0;
      pixel_column_next   = '0;
      pixel_assembly_next = 24'd0;
      byte_phase_next     = 2'd0;
      row_counter_next    = last_row ? 16'd0 : row_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_in_row    <= 15'd0;
      pixel_column   <= '0;
      row_counter    <= 16'd0;
      pixel_assembly <= 24'd0;
      byte_phase     <= 2'd0;
    end else if (data_take) begin
      byte_in_row    <= byte_in_row_next;
      pixel_column   <= pixel_column_next;
      row_counter    <= row_counter_next;
      pixel_assembly <= pixel_assembly_next;
      byte_phase     <= byte_phase_next;
    end
  end

  // palette index of the pixel being issued
  logic [7:0] lk_index;
  logic       lk_oor;

  always_comb begin
    case (j_kind)
      LK_BIT:    lk_index = {7'd0, j_bits[7]};
      LK_NIBBLE: lk_index = {4'd0, j_bits[7:4]};
      default:   lk_index = j_bits;
    endcase
    lk_oor = {1'b0, lk_index} >= 9'(PALETTE_DEPTH);
  end

  // job register
  always_ff @(posedge clk) begin
    if (rst) begin
      j_valid <= 1'b0;
    end else if (data_take && (n_pix != 4'd0)) begin
      j_valid <= 1'b1;
    end else if (j_done) begin
      j_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_take && (n_pix != 4'd0)) begin
      j_kind <= new_kind;
      j_bits <= data_byte;
      j_left <= n_pix;
      j_word <= new_word;
      j_eor  <= row_done;
      j_eoi  <= row_done && last_row;
    end else if (issue) begin
      j_left <= j_left - 4'd1;
      case (j_kind)
        LK_BIT:    j_bits <= {j_bits[6:0], 1'b0};
        LK_NIBBLE: j_bits <= {j_bits[3:0], 4'd0};
        default:   j_bits <= j_bits;
      endcase
    end
  end

  // palette memory
  logic [31:0] ram_rd;

  dibx_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .wr_en   (pal_take && ({1'b0, palette_index} < 9'(PALETTE_DEPTH))),
    .wr_addr (palette_index[AW-1:0]),
    .wr_data (palette_word),
    .rd_en   (issue),
    .rd_addr (lk_index[AW-1:0]),
    .rd_data (ram_rd)
  );

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (issue) begin
      r_valid <= 1'b1;
    end else if (r_move) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r_use_ram <= (j_kind != LK_DIRECT) && !lk_oor;
      r_word    <= (j_kind == LK_DIRECT) ? j_word : 32'd0;
      r_last    <= j_left == 4'd1;
      r_eor     <= (j_left == 4'd1) && j_eor;
      r_eoi     <= (j_left == 4'd1) && j_eoi;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (r_move) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (r_move) begin
      pixel_word   <= r_use_ram ? ram_rd : r_word;
      end_of_row   <= r_eor;
      end_of_image <= r_eoi;
      last_of_item <= r_last;
    end
  end

  // checks
  a_stall_needs_job: assert property (@(posedge clk) disable iff (rst)
    !j_valid |-> !src_stall)
    else $error("source stalled with no pending job");

  a_job_count: assert property (@(posedge clk) disable iff (rst)
    j_valid |-> (j_left != 4'd0) && (j_left <= 4'd8))
    else $error("pending job holds a bad pixel count");

  a_eoi_is_eor: assert property (@(posedge clk) disable iff (rst)
    pix_valid && end_of_image |-> end_of_row)
    else $error("end of image without end of row");

  a_eor_is_last: assert property (@(posedge clk) disable iff (rst)
    pix_valid && end_of_row |-> last_of_item)
    else $error("end of row not on the last pixel of its byte");

  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    issue |=> r_valid)
    else $error("issued palette read lost in the read stage");

endmodule

@@ bench/dib_row_pixel_expander_tb.sv @@
module dib_row_pixel_expander_tb;
  import dibx_pkg::*;

  // bit_mode codes that name no pixel depth
  localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
  localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;
  localparam int unsigned MAX_PIXELS = MAX_WIDTH_DEF;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 10;
  localparam int TOTAL_WORDS = 250;

  // one expected pixel word
  typedef struct packed {
    logic [31:0] color;
    logic        row_end;
    logic        image_end;
    logic        byte_end;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        src_valid;
  logic        src_stall;
  logic        opcode;
  logic [7:0]  palette_index;
  logic [31:0] palette_word;
  logic [7:0]  data_byte;
  logic        pix_valid;
  logic        pix_stall;
  logic [31:0] pixel_word;
  logic        end_of_row;
  logic        end_of_image;
  logic        last_of_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor copy of the registers
  logic [2:0]  mode_reg   = BIT_MODE_RST;
  logic [12:0] width_reg  = ROW_WIDTH_RST;
  logic [14:0] stride_reg = ROW_STRIDE_RST;
  logic [15:0] rows_reg   = IMAGE_ROWS_RST;

  // predictor copy of the row state
  logic [31:0] pal_mem [256];
  bit          pal_known [256];
  int unsigned byte_pos  = 0;
  int unsigned column    = 0;
  int unsigned row_count = 0;
  logic [23:0] assembly  = '0;
  int unsigned phase     = 0;

  pixel_t pixels_due [$];

  bit src_calm = 1'b0;
  bit sink_calm = 1'b0;
  bit long_hold_req = 1'b0;
  int words_sent = 0;
  int pixels_checked = 0;
  int cfg_writes = 0;
  int err_cnt = 0;

  always #5 clk = ~clk;

  dib_row_pixel_expander i_dut (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .opcode        (opcode),
    .palette_index (palette_index),
    .palette_word  (palette_word),
    .data_byte     (data_byte),
    .pix_valid     (pix_valid),
    .pix_stall     (pix_stall),
    .pixel_word    (pixel_word),
    .end_of_row    (end_of_row),
    .end_of_image  (end_of_image),
    .last_of_item  (last_of_item),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // work out the pixel words one accepted source word gives
  task automatic expand_word(input logic op, input logic [7:0] idx, input logic [31:0] value,
                             input logic [7:0] byt);
    logic [31:0] colors [8];
    int          n;
    int          k;
    int unsigned limit;
    int unsigned rows;
    int unsigned stride;
    int unsigned remaining;
    bit          row_done;
    pixel_t      px;
    if (op == OPC_PALETTE) begin
      pal_mem[idx] = value;
      pal_known[idx] = 1'b1;
    end else begin
      n = 0;
      limit = (width_reg > MAX_PIXELS) ? MAX_PIXELS : width_reg;
      rows = (rows_reg == 0) ? 1 : rows_reg;
      stride = (stride_reg == 0) ? 1 : stride_reg;
      remaining = (column < limit) ? limit - column : 0;
      if (remaining > 0) begin
        case (mode_reg)
          MODE_1BPP: begin
            for (k = 0; k < 8 && k < remaining; k++) begin
              colors[n] = pal_mem[{7'd0, byt[7 - k]}];
              n++;
            end
          end
          MODE_4BPP: begin
            colors[n] = pal_mem[{4'd0, byt[7:4]}];
            n++;
            if (remaining > 1) begin
              colors[n] = pal_mem[{4'd0, byt[3:0]}];
              n++;
            end
          end
          MODE_8BPP: begin
            colors[n] = pal_mem[byt];
            n++;
          end
          MODE_24BPP: begin
            if (phase >= 2) begin
              colors[n] = {8'h00, byt, assembly[15:0]};
              n++;
              assembly = '0;
              phase = 0;
            end else begin
              assembly = assembly | (24'(byt) << (8 * phase));
              phase++;
            end
          end
          MODE_32BPP: begin
            if (phase >= 3) begin
              colors[n] = {byt, assembly};
              n++;
              assembly = '0;
              phase = 0;
            end else begin
              assembly = assembly | (24'(byt) << (8 * phase));
              phase++;
            end
          end
          default: ;
        endcase
      end
      column += n;
      row_done = (n > 0) && (column >= limit);
      for (k = 0; k < n; k++) begin
        px.color = colors[k];
        px.byte_end = (k == n - 1);
        px.row_end = px.byte_end && row_done;
        px.image_end = px.row_end && (row_count + 1 >= rows);
        pixels_due.push_back(px);
      end
      // stride reached: next source row
      byte_pos++;
      if (byte_pos >= stride) begin
        byte_pos = 0;
        column = 0;
        assembly = '0;
        phase = 0;
        row_count++;
        if (row_count >= rows) row_count = 0;
      end
    end
  endtask

  // offer one source word after a random gap (none when src_calm is set) and wait until it is taken
  task automatic send_word(input logic op, input logic [7:0] idx, input logic [31:0] value,
                           input logic [7:0] byt);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_valid <= 1'b1;
    opcode <= op;
    palette_index <= idx;
    palette_word <= value;
    data_byte <= byt;
    do @(posedge clk); while (src_stall);
    expand_word(op, idx, value, byt);
    words_sent++;
  endtask

  // a colored palette entry for every index the byte may look up that has none yet, then the byte itself
  task automatic send_pixel_byte(input logic [7:0] byt);
    logic [7:0] need [2];
    int         cnt;
    int         j;
    cnt = 0;
    case (mode_reg)
      MODE_1BPP: begin
        need[0] = 8'd0;
        need[1] = 8'd1;
        cnt = 2;
      end
      MODE_4BPP: begin
        need[0] = {4'd0, byt[7:4]};
        need[1] = {4'd0, byt[3:0]};
        cnt = 2;
      end
      MODE_8BPP: begin
        need[0] = byt;
        cnt = 1;
      end
      default: ;
    endcase
    for (j = 0; j < cnt; j++)
      if (!pal_known[need[j]]) send_word(OPC_PALETTE, need[j], $urandom, 8'($urandom));
    send_word(OPC_DATA, 8'($urandom), $urandom, byt);
  endtask

  // register write: setup then access cycle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BIT_MODE:   mode_reg = value[2:0];
      REG_ROW_WIDTH:  width_reg = value[12:0];
      REG_ROW_STRIDE: stride_reg = value[14:0];
      REG_IMAGE_ROWS: rows_reg = value[15:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_image(input logic [2:0] mode, input logic [12:0] cols,
                           input logic [14:0] stride, input logic [15:0] rows);
    write_reg(REG_BIT_MODE, 32'(mode));
    write_reg(REG_ROW_WIDTH, 32'(cols));
    write_reg(REG_ROW_STRIDE, 32'(stride));
    write_reg(REG_IMAGE_ROWS, 32'(rows));
  endtask

  // drop valid, wait for every expected pixel and let words without pixels settle
  task automatic wait_drain();
    @(negedge clk);
    src_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // reset settings: 8 bpp, one pixel per row, four-byte stride
  task automatic test_default_config();
    send_word(OPC_PALETTE, 8'd0, 32'h0000_0000, 8'hff);
    send_word(OPC_PALETTE, 8'd255, 32'hffff_ffff, 8'h00);
    send_pixel_byte(8'hff);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'ha5);
    send_pixel_byte(8'h5a);
  endtask

  // 1 and 4 bpp with a partial last byte
  task automatic test_palette_modes();
    wait_drain();
    set_image(MODE_1BPP, 13'd11, 15'd2, 16'd2);
    send_pixel_byte(8'ha5);
    send_pixel_byte(8'he0);
    send_pixel_byte(8'h5a);
    send_pixel_byte(8'h1f);
    wait_drain();
    set_image(MODE_4BPP, 13'd3, 15'd2, 16'd1);
    send_pixel_byte(8'h0f);
    send_pixel_byte(8'hf3);
  endtask

  // 24 and 32 bpp assembly, padding, palette write inside a row
  task automatic test_direct_color();
    wait_drain();
    set_image(MODE_24BPP, 13'd2, 15'd8, 16'd1);
    send_pixel_byte(8'h11);
    send_pixel_byte(8'h22);
    send_word(OPC_PALETTE, 8'h80, 32'h8000_0001, 8'h00);
    send_pixel_byte(8'h33);
    send_pixel_byte(8'h44);
    send_pixel_byte(8'h55);
    send_pixel_byte(8'h66);
    send_pixel_byte(8'h00);
    send_pixel_byte(8'hff);
    wait_drain();
    set_image(MODE_32BPP, 13'd1, 15'd4, 16'd1);
    send_pixel_byte(8'h01);
    send_pixel_byte(8'h02);
    send_pixel_byte(8'h03);
    send_pixel_byte(8'hfe);
  endtask

  // undefined depth, zero registers, stride shorter than the pixels
  task automatic test_corner_settings();
    wait_drain();
    set_image(MODE_RSVD_LAST, 13'd4, 15'd2, 16'd1);
    send_pixel_byte(8'hc3);
    send_pixel_byte(8'h3c);
    wait_drain();
    set_image(MODE_8BPP, 13'd0, 15'd0, 16'd0);
    send_pixel_byte(8'h01);
    send_pixel_byte(8'h02);
    wait_drain();
    set_image(MODE_1BPP, 13'd20, 15'd1, 16'd3);
    send_pixel_byte(8'hc3);
    send_pixel_byte(8'h96);
  endtask

  // output held off for a long stretch while words keep coming
  task automatic test_backpressure();
    int j;
    wait_drain();
    set_image(MODE_1BPP, 13'd64, 15'd8, 16'd2);
    long_hold_req = 1'b1;
    src_calm = 1'b1;
    for (j = 0; j < 16; j++) send_pixel_byte(8'($urandom));
    src_calm = 1'b0;
  endtask

  // random images, mostly whole rows, some cut short, with stray palette writes
  task automatic test_random_frames();
    int          nbytes;
    int          need;
    int          j;
    logic [2:0]  mode;
    logic [12:0] cols;
    logic [14:0] stride;
    logic [15:0] rows;
    int unsigned eff_cols;
    while (words_sent < TOTAL_WORDS) begin
      wait_drain();
      src_calm = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0)
        mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
      else
        mode = 3'($urandom_range(MODE_1BPP, MODE_32BPP));
      case ($urandom_range(0, 11))
        0: cols = 13'd0;
        1: cols = 13'h1fff;
        2: cols = 13'(MAX_PIXELS);
        default: cols = 13'($urandom_range(1, 9));
      endcase
      eff_cols = (cols > MAX_PIXELS) ? MAX_PIXELS : cols;
      case (mode)
        MODE_1BPP:  need = (eff_cols + 7) / 8;
        MODE_4BPP:  need = (eff_cols + 1) / 2;
        MODE_24BPP: need = 3 * eff_cols;
        MODE_32BPP: need = 4 * eff_cols;
        default:    need = eff_cols;
      endcase
      need = ((need + 3) / 4) * 4 + 4 * $urandom_range(0, 1);
      if (need == 0) need = 4;
      if (need > 32767) need = 32767;
      case ($urandom_range(0, 9))
        0: stride = 15'd0;
        1: stride = 15'($urandom_range(1, 2));
        2: stride = 15'h7fff;
        default: stride = 15'(need);
      endcase
      case ($urandom_range(0, 9))
        0: rows = 16'd0;
        1: rows = 16'hffff;
        default: rows = 16'($urandom_range(1, 2));
      endcase
      set_image(mode, cols, stride, rows);
      nbytes = ((stride == 0) ? 1 : stride) * ((rows == 0) ? 1 : rows);
      if (nbytes > 64) nbytes = 64;
      if ($urandom_range(0, 5) == 0) nbytes = $urandom_range(1, nbytes);
      for (j = 0; j < nbytes && words_sent < TOTAL_WORDS; j++) begin
        if ($urandom_range(0, 9) == 0)
          send_word(OPC_PALETTE, 8'($urandom), $urandom, 8'($urandom));
        send_pixel_byte(8'($urandom));
      end
    end
    src_calm = 1'b0;
    sink_calm = 1'b0;
  endtask

  // pixel side stall: a random hold before each word, or one long hold on request
  initial begin : pix_sink
    int hold;
    hold = 0;
    pix_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold > 0) begin
        pix_stall <= 1'b1;
        hold--;
      end else begin
        pix_stall <= 1'b0;
      end
      @(posedge clk);
      if (pix_valid === 1'b1 && !pix_stall) hold = sink_calm ? 0 : $urandom_range(0, 10);
    end
  end

  // compare each taken pixel word with the oldest expected one
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pix_valid === 1'b1 && !pix_stall) begin
      if (pixels_due.size() == 0) begin
        $error("pixel_word 0x%08h arrived with nothing expected", pixel_word);
        err_cnt++;
      end else begin
        want = pixels_due.pop_front();
        pixels_checked++;
        if (pixel_word !== want.color) begin
          $error("pixel_word: expected 0x%08h, got 0x%08h", want.color, pixel_word);
          err_cnt++;
        end
        if (end_of_row !== want.row_end) begin
          $error("end_of_row: expected %0b, got %0b", want.row_end, end_of_row);
          err_cnt++;
        end
        if (end_of_image !== want.image_end) begin
          $error("end_of_image: expected %0b, got %0b", want.image_end, end_of_image);
          err_cnt++;
        end
        if (last_of_item !== want.byte_end) begin
          $error("last_of_item: expected %0b, got %0b", want.byte_end, last_of_item);
          err_cnt++;
        end
      end
    end
  end

  // test sequence
  initial begin
    rst = 1'b1;
    src_valid = 1'b0;
    opcode = OPC_PALETTE;
    palette_index = '0;
    palette_word = '0;
    data_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_default_config();
    test_palette_modes();
    test_direct_color();
    test_corner_settings();
    test_backpressure();
    test_random_frames();
    wait_drain();
    $display("covered %0d source words and %0d pixel words under %0d register writes",
             words_sent, pixels_checked, cfg_writes);
    $display("all depths, partial bytes, padding, odd strides and a long output hold ran");
    if (err_cnt == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ filelist.f @@
src/dibx_pkg.sv
src/dibx_ram.sv
src/dib_row_pixel_expander.sv
bench/dib_row_pixel_expander_tb.sv
